// File: design/segment_intersection_point_unit_macros.svh
// Assertion helpers for the segment intersection point unit.
`ifndef SEGMENT_INTERSECTION_POINT_UNIT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIPU_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIPU_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sipu_pkg.sv
package sipu_pkg;

    localparam int CB      = 16;          // coordinate width
    localparam int DIFF_W  = CB + 1;      // coordinate difference
    localparam int PROD_W  = 2 * CB + 2;  // product of two differences
    localparam int DET_W   = 2 * CB + 3;  // determinant
    localparam int CROSS_W = 2 * CB + 1;  // endpoint cross product
    localparam int CHI_W   = CROSS_W - CB;
    localparam int NUM_W   = 3 * CB + 4;  // intersection numerator
    localparam int REM_W   = 3 * CB + 5;  // divider remainder

    typedef logic signed [CB-1:0]     t_coord;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_end_x;
        t_coord b_end_y;
    } t_req;

    typedef struct packed {
        logic   hit;
        t_coord cross_x;
        t_coord cross_y;
    } t_res;

    // Common extent of both segments on each axis.
    typedef struct packed {
        t_coord xlo;
        t_coord xhi;
        t_coord ylo;
        t_coord yhi;
    } t_bounds;

    // Word handed from cell to cell along the divider chain.
    typedef struct packed {
        logic [REM_W-1:0] rem_x;
        logic [REM_W-1:0] rem_y;
        logic [REM_W-1:0] den;
        logic [CB-1:0]    q_x;
        logic [CB-1:0]    q_y;
        logic             fail;
        t_bounds          bnd;
    } t_cell;

endpackage

// File: design/sipu_front.sv
module sipu_front
    import sipu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_req  i_req,
    output logic  o_valid,
    output t_cell o_cell
);

    // Stage 1: differences, products, extents.
    t_diff   exa, eya, exb, eyb;
    t_bounds n1_bnd;
    t_coord  lo_a, hi_a, lo_b, hi_b, ylo_a, yhi_a, ylo_b, yhi_b;
    logic    r1_valid;
    t_diff   r1_exa, r1_eya, r1_exb, r1_eyb;
    t_prod   r1_p1, r1_p2;
    logic signed [2*CB-1:0] r1_m0, r1_m1, r1_m2, r1_m3;
    t_bounds r1_bnd;

    always_comb begin
        exa = DIFF_W'(i_req.a_start_x) - DIFF_W'(i_req.a_end_x);
        eya = DIFF_W'(i_req.a_start_y) - DIFF_W'(i_req.a_end_y);
        exb = DIFF_W'(i_req.b_start_x) - DIFF_W'(i_req.b_end_x);
        eyb = DIFF_W'(i_req.b_start_y) - DIFF_W'(i_req.b_end_y);
        lo_a  = (i_req.a_start_x < i_req.a_end_x) ? i_req.a_start_x : i_req.a_end_x;
        hi_a  = (i_req.a_start_x < i_req.a_end_x) ? i_req.a_end_x : i_req.a_start_x;
        lo_b  = (i_req.b_start_x < i_req.b_end_x) ? i_req.b_start_x : i_req.b_end_x;
        hi_b  = (i_req.b_start_x < i_req.b_end_x) ? i_req.b_end_x : i_req.b_start_x;
        ylo_a = (i_req.a_start_y < i_req.a_end_y) ? i_req.a_start_y : i_req.a_end_y;
        yhi_a = (i_req.a_start_y < i_req.a_end_y) ? i_req.a_end_y : i_req.a_start_y;
        ylo_b = (i_req.b_start_y < i_req.b_end_y) ? i_req.b_start_y : i_req.b_end_y;
        yhi_b = (i_req.b_start_y < i_req.b_end_y) ? i_req.b_end_y : i_req.b_start_y;
        n1_bnd.xlo = (lo_a > lo_b) ? lo_a : lo_b;
        n1_bnd.xhi = (hi_a < hi_b) ? hi_a : hi_b;
        n1_bnd.ylo = (ylo_a > ylo_b) ? ylo_a : ylo_b;
        n1_bnd.yhi = (yhi_a < yhi_b) ? yhi_a : yhi_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_exa <= exa;
        r1_eya <= eya;
        r1_exb <= exb;
        r1_eyb <= eyb;
        r1_p1  <= PROD_W'(eyb * exa);
        r1_p2  <= PROD_W'(exb * eya);
        r1_m0  <= (2*CB)'(i_req.a_start_x * i_req.a_end_y);
        r1_m1  <= (2*CB)'(i_req.a_start_y * i_req.a_end_x);
        r1_m2  <= (2*CB)'(i_req.b_start_x * i_req.b_end_y);
        r1_m3  <= (2*CB)'(i_req.b_start_y * i_req.b_end_x);
        r1_bnd <= n1_bnd;
    end

    // Stage 2: determinant and cross products.
    logic                     r2_valid;
    logic signed [DET_W-1:0]  r2_d;
    logic signed [CROSS_W-1:0] r2_ca, r2_cb;
    t_diff   r2_exa, r2_eya, r2_exb, r2_eyb;
    t_bounds r2_bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_d   <= DET_W'(r1_p1) - DET_W'(r1_p2);
        r2_ca  <= CROSS_W'(r1_m0) - CROSS_W'(r1_m1);
        r2_cb  <= CROSS_W'(r1_m2) - CROSS_W'(r1_m3);
        r2_exa <= r1_exa;
        r2_eya <= r1_eya;
        r2_exb <= r1_exb;
        r2_eyb <= r1_eyb;
        r2_bnd <= r1_bnd;
    end

    // Stage 3: partial products of the numerators, cross products split in halves.
    logic signed [CHI_W-1:0] ca_hi, cb_hi;
    t_diff   ca_lo, cb_lo;
    logic    r3_valid;
    t_prod   r3_xh1, r3_xh2, r3_xl1, r3_xl2, r3_yh1, r3_yh2, r3_yl1, r3_yl2;
    logic signed [DET_W-1:0] r3_d;
    t_bounds r3_bnd;

    always_comb begin
        ca_hi = r2_ca[CROSS_W-1:CB];
        cb_hi = r2_cb[CROSS_W-1:CB];
        ca_lo = {1'b0, r2_ca[CB-1:0]};
        cb_lo = {1'b0, r2_cb[CB-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_xh1 <= PROD_W'(r2_exb * ca_hi);
        r3_xh2 <= PROD_W'(r2_exa * cb_hi);
        r3_xl1 <= PROD_W'(r2_exb * ca_lo);
        r3_xl2 <= PROD_W'(r2_exa * cb_lo);
        r3_yh1 <= PROD_W'(r2_eyb * ca_hi);
        r3_yh2 <= PROD_W'(r2_eya * cb_hi);
        r3_yl1 <= PROD_W'(r2_eyb * ca_lo);
        r3_yl2 <= PROD_W'(r2_eya * cb_lo);
        r3_d   <= r2_d;
        r3_bnd <= r2_bnd;
    end

    // Stage 4: full numerators.
    logic                    r4_valid;
    logic signed [NUM_W-1:0] r4_nx, r4_ny;
    logic signed [DET_W-1:0] r4_d;
    t_bounds                 r4_bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_nx  <= ((NUM_W'(r3_xh1) - NUM_W'(r3_xh2)) <<< CB)
                  + (NUM_W'(r3_xl1) - NUM_W'(r3_xl2));
        r4_ny  <= ((NUM_W'(r3_yh1) - NUM_W'(r3_yh2)) <<< CB)
                  + (NUM_W'(r3_yl1) - NUM_W'(r3_yl2));
        r4_d   <= r3_d;
        r4_bnd <= r3_bnd;
    end

    // Stage 5: make the divisor positive.
    logic                    r5_valid, r5_zero;
    logic signed [NUM_W-1:0] r5_pnx, r5_pny;
    logic signed [DET_W-1:0] r5_pd;
    t_bounds                 r5_bnd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_zero <= (r4_d == '0);
        r5_pd   <= r4_d[DET_W-1] ? -r4_d : r4_d;
        r5_pnx  <= r4_d[DET_W-1] ? -r4_nx : r4_nx;
        r5_pny  <= r4_d[DET_W-1] ? -r4_ny : r4_ny;
        r5_bnd  <= r4_bnd;
    end

    // Stage 6: bias the numerators so the floor quotient becomes an unsigned
    // CB-bit value, and flag a zero divisor or quotients that fall off either end of that range.
    logic signed [REM_W-1:0] mx, my, lim, bias;
    logic  n6_fail;
    logic  r6_valid;
    t_cell r6_cell;

    always_comb begin
        bias    = REM_W'(r5_pd) <<< (CB - 1);
        lim     = REM_W'(r5_pd) <<< CB;
        mx      = REM_W'(r5_pnx) + bias;
        my      = REM_W'(r5_pny) + bias;
        n6_fail = r5_zero || mx < 0 || my < 0 || mx >= lim || my >= lim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_cell.rem_x <= mx;
        r6_cell.rem_y <= my;
        r6_cell.den   <= REM_W'(r5_pd);
        r6_cell.q_x   <= '0;
        r6_cell.q_y   <= '0;
        r6_cell.fail  <= n6_fail;
        r6_cell.bnd   <= r5_bnd;
    end

    assign o_valid = r6_valid;
    assign o_cell  = r6_cell;

endmodule

// File: design/sipu_cell.sv
module sipu_cell
    import sipu_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cell i_cell,
    output logic  o_valid,
    output t_cell o_cell
);

    logic [REM_W-1:0] shifted;
    t_cell n_cell;
    logic  r_valid;
    t_cell r_cell;

    // One restoring division step for both axes.
    always_comb begin
        shifted = i_cell.den << BIT;
        n_cell  = i_cell;
        if (i_cell.rem_x >= shifted) begin
            n_cell.rem_x    = i_cell.rem_x - shifted;
            n_cell.q_x[BIT] = 1'b1;
        end
        if (i_cell.rem_y >= shifted) begin
            n_cell.rem_y    = i_cell.rem_y - shifted;
            n_cell.q_y[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_cell <= n_cell;
    end

    assign o_valid = r_valid;
    assign o_cell  = r_cell;

endmodule

// File: design/segment_intersection_point_unit.sv
// Segment intersection point unit. Each request carries two segments A and B
// as signed 16-bit start and end points; the unit answers with hit and the
// crossing point, truncated toward zero, or zeros when the segments do not
// meet (parallel, degenerate or outside either segment's extent; touching
// endpoints count as a hit). A request is taken on any cycle start is high:
// busy never rises, so one request per cycle is sustained. Every answer
// appears on o_res for exactly one cycle with o_done high, in request
// order. The receiver cannot stall the unit, so it must take each answer
// in the cycle it is shown. The pipeline is made of six arithmetic stages,
// a chain of 16 divider cells each producing one quotient bit of both
// coordinates, and the output register.
`include "segment_intersection_point_unit_macros.svh"

module segment_intersection_point_unit
    import sipu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    // The pipeline never holds a request back.
    assign busy = 1'b0;

    logic  w_valid [0:CB];
    t_cell w_cell  [0:CB];

    sipu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_req   (i_req),
        .o_valid (w_valid[0]),
        .o_cell  (w_cell[0])
    );

    // Cell i decides quotient bit CB-1-i, most significant first.
    for (genvar gi = 0; gi < CB; gi++) begin : g_cell
        sipu_cell #(
            .BIT (CB - 1 - gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[gi]),
            .i_cell  (w_cell[gi]),
            .o_valid (w_valid[gi+1]),
            .o_cell  (w_cell[gi+1])
        );
    end

    // The chain yields the floor quotient offset by half the range; flipping
    // the top bit removes that offset. The floor is checked against the
    // common extent (the upper bound is met exactly only with no remainder)
    // and then rounded toward zero.
    t_cell  last;
    t_coord qx, qy;
    logic   in_x, in_y;
    t_res   n_res;
    logic   r_done;
    t_res   r_res;

    always_comb begin
        last = w_cell[CB];
        qx   = {~last.q_x[CB-1], last.q_x[CB-2:0]};
        qy   = {~last.q_y[CB-1], last.q_y[CB-2:0]};
        in_x = qx >= last.bnd.xlo
               && (qx < last.bnd.xhi || (qx == last.bnd.xhi && last.rem_x == '0));
        in_y = qy >= last.bnd.ylo
               && (qy < last.bnd.yhi || (qy == last.bnd.yhi && last.rem_y == '0));
        n_res = '0;
        if (!last.fail && in_x && in_y) begin
            n_res.hit     = 1'b1;
            n_res.cross_x = qx + t_coord'(qx[CB-1] && last.rem_x != '0);
            n_res.cross_y = qy + t_coord'(qy[CB-1] && last.rem_y != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_valid[CB];
        end
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `SIPU_CHECK(a_nohit_zero, o_done && !o_res.hit, o_res.cross_x == '0 && o_res.cross_y == '0, "miss with nonzero point")
    `SIPU_CHECK(a_fail_no_hit, w_valid[CB] && last.fail, !n_res.hit, "hit despite failed range")
    `SIPU_CHECK_NEXT(a_done_follows, w_valid[CB], o_done, "finished request not shown")

endmodule
